// ===== design/oled_big_digit_renderer_assert.svh =====
// Assertion macros shared by the checker of the big digit renderer.
`ifndef OLED_BIG_DIGIT_RENDERER_ASSERT_SVH
`define OLED_BIG_DIGIT_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define OBD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define OBD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/obd_pkg.sv =====
// Types, constants and the digit font shared by the big digit renderer modules.
package obd_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int GLYPH_W    = 16;
    localparam int GLYPH_ROWS = 3;
    localparam int MAX_WORDS  = 32;
    localparam int CMD_LEN    = 7;

    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE = 8'h22;
    localparam logic [7:0] CMD_SET_COL  = 8'h21;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd60;

    // Division by ten of a 16-bit value: (n * RECIP_10) >> DIV10_SHIFT.
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        t_digit [MAX_DIGITS-1:0] digits;
        logic [2:0]              n_digits;
        logic [6:0]              column;
        logic [2:0]              page;
    } t_job;

    typedef struct packed {
        logic [1:0] row;
        logic [2:0] dig;
        logic [3:0] col;
    } t_pos;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CMD,
        B_DATA
    } t_back_state;

    localparam logic [7:0] GLYPH_ROM [10][3][16] = '{
        '{'{8'h00,8'h00,8'hC0,8'hE0,8'h60,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h60,8'hE0,8'hC0,8'h00,8'h00},
          '{8'h00,8'hFF,8'hFF,8'h01,8'h00,8'h00,8'h00,8'h00,
            8'h00,8'h00,8'h00,8'h00,8'h01,8'hFF,8'hFF,8'h00},
          '{8'h00,8'h01,8'h07,8'h0F,8'h0C,8'h18,8'h18,8'h18,
            8'h18,8'h18,8'h18,8'h1C,8'h0F,8'h07,8'h01,8'h00}},
        '{'{8'h00,8'h00,8'h00,8'h80,8'h80,8'hC0,8'h60,8'h60,
            8'h70,8'hF0,8'hF0,8'h00,8'h00,8'h00,8'h00,8'h00},
          '{8'h00,8'h00,8'h00,8'h01,8'h01,8'h00,8'h00,8'h00,
            8'h00,8'hFF,8'hFF,8'h00,8'h00,8'h00,8'h00,8'h00},
          '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
            8'h1A,8'h1F,8'h1F,8'h00,8'h00,8'h00,8'h00,8'h00}},
        '{'{8'h00,8'h00,8'hC0,8'hE0,8'h60,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h60,8'hE0,8'hC0,8'h00,8'h00},
          '{8'h00,8'h00,8'h01,8'h01,8'h00,8'h00,8'h80,8'hC0,
            8'hE0,8'h70,8'h38,8'h1C,8'h0F,8'h07,8'h00,8'h00},
          '{8'h00,8'h00,8'h18,8'h1C,8'h1E,8'h1F,8'h1B,8'h19,
            8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h10,8'h00}},
        '{'{8'h00,8'h00,8'hC0,8'hE0,8'h60,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h70,8'hE0,8'hC0,8'h00,8'h00},
          '{8'h00,8'h00,8'h01,8'h01,8'h00,8'h10,8'h18,8'h18,
            8'h18,8'h18,8'h38,8'h3C,8'h67,8'hE7,8'hC0,8'h00},
          '{8'h00,8'h00,8'h07,8'h0E,8'h1C,8'h18,8'h18,8'h18,
            8'h10,8'h18,8'h18,8'h18,8'h0E,8'h0F,8'h03,8'h00}},
        '{'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,
            8'hE0,8'h70,8'h70,8'hF0,8'hF0,8'h00,8'h00,8'h00},
          '{8'h00,8'h80,8'hE0,8'hF0,8'h38,8'h9E,8'h07,8'h03,
            8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'h00,8'h00,8'h00},
          '{8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
            8'h01,8'h01,8'h1F,8'h1F,8'h1F,8'h01,8'h01,8'h00}},
        '{'{8'h00,8'h00,8'h00,8'hF0,8'hF0,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,8'h00,8'h00},
          '{8'h00,8'h00,8'h3F,8'h3F,8'h19,8'h0C,8'h0C,8'h0C,
            8'h0C,8'h0C,8'h0C,8'h1C,8'h38,8'hF0,8'hE0,8'h00},
          '{8'h00,8'h00,8'h07,8'h0F,8'h1C,8'h18,8'h18,8'h18,
            8'h10,8'h18,8'h18,8'h1C,8'h0E,8'h07,8'h03,8'h00}},
        '{'{8'h00,8'h00,8'h80,8'hC0,8'hE0,8'h70,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h70,8'hE0,8'hC0,8'h80,8'h00},
          '{8'h00,8'hFE,8'hFF,8'hFB,8'h18,8'h0C,8'h0C,8'h0C,
            8'h0C,8'h0C,8'h0C,8'h1C,8'h38,8'hF0,8'hE0,8'h00},
          '{8'h00,8'h00,8'h03,8'h0F,8'h0C,8'h18,8'h18,8'h18,
            8'h18,8'h18,8'h18,8'h1C,8'h0E,8'h07,8'h03,8'h00}},
        '{'{8'h00,8'h00,8'h30,8'h30,8'h30,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'hB0,8'hF0,8'hF0,8'h30,8'h00},
          '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hC0,
            8'hF0,8'h78,8'h1E,8'h07,8'h03,8'h00,8'h00,8'h00},
          '{8'h00,8'h00,8'h00,8'h00,8'h18,8'h1E,8'h0F,8'h03,
            8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}},
        '{'{8'h00,8'h00,8'hC0,8'hE0,8'h60,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h60,8'hE0,8'hC0,8'h00,8'h00},
          '{8'h00,8'hC0,8'hE3,8'h67,8'h3C,8'h38,8'h18,8'h18,
            8'h18,8'h18,8'h18,8'h3C,8'h67,8'hE3,8'hC0,8'h00},
          '{8'h00,8'h03,8'h07,8'h0E,8'h1C,8'h18,8'h18,8'h18,
            8'h10,8'h18,8'h18,8'h1C,8'h0E,8'h0F,8'h03,8'h00}},
        '{'{8'h00,8'h00,8'hC0,8'hE0,8'h60,8'h30,8'h30,8'h30,
            8'h30,8'h30,8'h30,8'h60,8'hE0,8'hC0,8'h00,8'h00},
          '{8'h00,8'h0F,8'h1F,8'h3D,8'h70,8'h60,8'h60,8'h60,
            8'h40,8'h60,8'h60,8'h30,8'h3D,8'hFF,8'hFF,8'h00},
          '{8'h00,8'h00,8'h06,8'h0E,8'h1C,8'h18,8'h18,8'h18,
            8'h18,8'h18,8'h18,8'h0C,8'h0F,8'h07,8'h01,8'h00}}
    };

    function automatic logic [7:0] glyph_byte(input t_digit d, input logic [1:0] row,
                                              input logic [3:0] col);
        logic [7:0] b;
        b = 8'h00;
        if (d <= 4'd9 && row <= 2'd2) begin
            b = GLYPH_ROM[d][row][col];
        end
        return b;
    endfunction

endpackage

// ===== design/obd_front.sv =====
// Front end: accepts a request and splits the number into decimal digits.
module obd_front
    import obd_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_push,
    output logic        o_in_full,
    input  logic [15:0] i_number,
    input  logic [6:0]  i_column,
    input  logic [2:0]  i_page,
    output logic        o_job_push,
    output t_job        o_job,
    input  logic        i_job_full
);

    t_front_state           r_state;
    t_front_state           n_state;
    logic [NUMBER_BITS-1:0] r_num;
    t_job                   r_job;

    logic [15:0] num16;
    logic [31:0] product;
    logic [15:0] quot;
    logic [15:0] remainder;
    logic        conv_done;

    assign num16     = 16'(r_num);
    assign product   = 32'(num16) * 32'(RECIP_10);
    assign quot      = 16'(product >> DIV10_SHIFT);
    assign remainder = num16 - (quot << 3) - (quot << 1);
    assign conv_done = (r_num == '0) || (r_job.n_digits == 3'(MAX_DIGITS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_in_push) begin
                    n_state = F_CONV;
                end
            end
            F_CONV: begin
                if (conv_done) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_full  = (r_state != F_IDLE);
        o_job_push = (r_state == F_PUSH);
    end

    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_push) begin
            r_num          <= i_number[NUMBER_BITS-1:0];
            r_job.column   <= i_column;
            r_job.page     <= i_page;
            r_job.n_digits <= 3'd0;
            r_job.digits   <= '0;
        end else if (r_state == F_CONV) begin
            if (!conv_done) begin
                r_job.digits[r_job.n_digits] <= remainder[3:0];
                r_job.n_digits               <= r_job.n_digits + 3'd1;
                r_num                        <= NUMBER_BITS'(quot);
            end else if (r_job.n_digits == 3'd0) begin
                // Zero is shown as a single digit.
                r_job.digits[0] <= 4'd0;
                r_job.n_digits  <= 3'd1;
            end
        end
    end

endmodule

// ===== design/obd_queue.sv =====
// Two-entry job queue between the digit front end and the stream sequencer.
module obd_queue
    import obd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/obd_back.sv =====
// Back end: sequences the command and glyph byte stream into output words.
module obd_back
    import obd_pkg::*;
#(
    parameter int BYTES_PER_WORD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_empty,
    output logic        o_job_pop,
    input  logic [6:0]  i_device_address,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_payload,
    output logic [3:0]  o_byte_count,
    output logic        o_is_data,
    output logic        o_starts_transfer,
    output logic        o_ends_transfer,
    output logic [6:0]  o_target_address,
    output logic        o_last
);

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    logic [7:0]  r_off;
    logic [4:0]  r_words;
    t_pos        r_pos;

    logic        r_out_valid;
    logic [63:0] r_payload;
    logic [3:0]  r_byte_count;
    logic        r_is_data;
    logic        r_starts;
    logic        r_ends;
    logic [6:0]  r_target;
    logic        r_last;

    logic        is_data;
    logic [7:0]  len;
    logic [7:0]  remaining;
    logic [3:0]  cnt;
    logic        ends;
    logic        first;
    logic        lead;
    logic        last_word;
    logic        advance_en;
    t_pos        base;
    t_pos        next_pos;
    logic [7:0]  cmd_bytes [CMD_LEN];
    t_pos        lane_pos [BYTES_PER_WORD];
    logic [7:0]  lane_byte [BYTES_PER_WORD];
    logic [63:0] word;

    function automatic t_pos advance(input t_pos p, input logic [3:0] amt,
                                     input logic [2:0] n);
        t_pos       q;
        logic [4:0] c;
        q = p;
        c = {1'b0, p.col} + {1'b0, amt};
        q.col = c[3:0];
        if (c[4]) begin
            if (p.dig + 3'd1 == n) begin
                q.dig = 3'd0;
                q.row = p.row + 2'd1;
            end else begin
                q.dig = p.dig + 3'd1;
            end
        end
        return q;
    endfunction

    assign is_data   = (r_state == B_DATA);
    assign len       = is_data ? 8'd1 + 8'(r_job.n_digits) * 8'(GLYPH_ROWS * GLYPH_W)
                               : 8'(CMD_LEN);
    assign remaining = len - r_off;
    assign cnt       = (remaining < 8'(BYTES_PER_WORD)) ? remaining[3:0]
                                                        : 4'(BYTES_PER_WORD);
    assign ends      = (remaining <= 8'(BYTES_PER_WORD));
    assign first     = (r_off == 8'd0);
    assign lead      = first && is_data;
    assign last_word = (is_data && ends) || (r_words == 5'(MAX_WORDS - 1));
    assign base      = first ? '0 : r_pos;
    assign next_pos  = advance(base, cnt - {3'd0, lead}, r_job.n_digits);

    always_comb begin
        cmd_bytes[0] = CTRL_CMD;
        cmd_bytes[1] = CMD_SET_PAGE;
        cmd_bytes[2] = {5'd0, r_job.page};
        cmd_bytes[3] = {5'd0, r_job.page} + 8'd2;
        cmd_bytes[4] = CMD_SET_COL;
        cmd_bytes[5] = {1'b0, r_job.column};
        cmd_bytes[6] = {1'b0, r_job.column} + {1'b0, r_job.n_digits, 4'd0} - 8'd1;
    end

    always_comb begin
        logic [7:0] idx;
        logic [2:0] didx;
        t_digit     dval;
        word = '0;
        for (int k = 0; k < BYTES_PER_WORD; k++) begin
            idx          = r_off + 8'(k);
            lane_pos[k]  = advance(base, 4'(k) - {3'd0, lead}, r_job.n_digits);
            didx         = r_job.n_digits - 3'd1 - lane_pos[k].dig;
            dval         = (didx < 3'(MAX_DIGITS)) ? r_job.digits[didx] : 4'd0;
            lane_byte[k] = 8'h00;
            if (4'(k) < cnt) begin
                if (!is_data) begin
                    lane_byte[k] = (idx < 8'(CMD_LEN)) ? cmd_bytes[idx[2:0]] : 8'h00;
                end else if (lead && k == 0) begin
                    lane_byte[k] = CTRL_DATA;
                end else begin
                    lane_byte[k] = glyph_byte(dval, lane_pos[k].row, lane_pos[k].col);
                end
            end
            word[8*k +: 8] = lane_byte[k];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    n_state = B_CMD;
                end
            end
            B_CMD: begin
                if (advance_en) begin
                    if (last_word) begin
                        n_state = B_IDLE;
                    end else if (ends) begin
                        n_state = B_DATA;
                    end
                end
            end
            B_DATA: begin
                if (advance_en && last_word) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = (r_state == B_IDLE) && !i_job_empty;
        advance_en = (r_state != B_IDLE) && (!r_out_valid || i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance_en) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job   <= i_job;
            r_off   <= 8'd0;
            r_words <= 5'd0;
            r_pos   <= '0;
        end else if (advance_en) begin
            r_off   <= ends ? 8'd0 : r_off + 8'(cnt);
            r_words <= r_words + 5'd1;
            r_pos   <= next_pos;
        end
        if (advance_en) begin
            r_payload    <= word;
            r_byte_count <= cnt;
            r_is_data    <= is_data;
            r_starts     <= first;
            r_ends       <= ends;
            r_target     <= i_device_address;
            r_last       <= last_word;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_payload         = r_payload;
    assign o_byte_count      = r_byte_count;
    assign o_is_data         = r_is_data;
    assign o_starts_transfer = r_starts;
    assign o_ends_transfer   = r_ends;
    assign o_target_address  = r_target;
    assign o_last            = r_last;

endmodule

// ===== design/oled_big_digit_renderer.sv =====
// Top level of the big digit renderer: front end, job queue, sequencer, config register.
//
// Requests enter through a queue-style port: a transaction is taken when push is high
// and full is low. Each request carries a number, a column and a page. The front end
// splits the number into decimal digits, one digit per cycle through a reciprocal
// multiplier, so full stays high until the finished job is pushed, and longer while
// the job queue is full. A two-entry job queue hands finished requests to the sequencer.
// The sequencer emits one output word per cycle while each word is popped: one or more
// command words, then the data words of the glyphs, at most 32 words per request. Between
// requests it passes through its idle state to take the next job; the sequencer sets
// the sustained rate. When the block is idle, the first word of a request passes through
// the front end, the job queue, the sequencer's idle state and its output register.
// Results leave through a queue-style port: the oldest word is shown while empty is low
// and is taken when pop is high. While pop stays low the word holds and the sequencer
// waits; the front end keeps accepting until the job queue fills.
// The device address register is written through its own valid/ready channel and is
// always ready. Reset clears all queues and returns the address to 60.
module oled_big_digit_renderer
    import obd_pkg::*;
#(
    parameter int NUMBER_BITS    = 16,
    parameter int BYTES_PER_WORD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_number,
    input  logic [6:0]  i_column,
    input  logic [2:0]  i_page,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_payload,
    output logic [3:0]  o_byte_count,
    output logic        o_is_data,
    output logic        o_starts_transfer,
    output logic        o_ends_transfer,
    output logic [6:0]  o_target_address,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    logic [6:0] r_device_address;

    t_job front_job;
    logic front_push;
    logic queue_full;
    t_job queue_job;
    logic queue_empty;
    logic queue_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_address <= i_cfg_data;
        end
    end

    obd_front #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_push  (push),
        .o_in_full  (full),
        .i_number   (i_number),
        .i_column   (i_column),
        .i_page     (i_page),
        .o_job_push (front_push),
        .o_job      (front_job),
        .i_job_full (queue_full)
    );

    obd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_data  (queue_job),
        .o_empty (queue_empty)
    );

    obd_back #(
        .BYTES_PER_WORD(BYTES_PER_WORD)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (queue_job),
        .i_job_empty       (queue_empty),
        .o_job_pop         (queue_pop),
        .i_device_address  (r_device_address),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_payload         (o_payload),
        .o_byte_count      (o_byte_count),
        .o_is_data         (o_is_data),
        .o_starts_transfer (o_starts_transfer),
        .o_ends_transfer   (o_ends_transfer),
        .o_target_address  (o_target_address),
        .o_last            (o_last)
    );

endmodule

// ===== design/obd_checker.sv =====
// Port-level assertions for the big digit renderer, bound to its top level.
`include "oled_big_digit_renderer_assert.svh"

module obd_checker
    import obd_pkg::*;
#(
    parameter int BYTES_PER_WORD = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_payload,
    input logic [3:0]  o_byte_count,
    input logic        o_is_data,
    input logic        o_starts_transfer,
    input logic        o_last
);

    `OBD_ASSERT_NOW(a_count_range, i_clk, i_rst_n, !empty, (o_byte_count != 4'd0) && (o_byte_count <= 4'(BYTES_PER_WORD)), "byte count out of range")

    `OBD_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, !empty, (o_payload >> {o_byte_count, 3'b000}) == 64'd0, "payload bytes past the count are not zero")

    `OBD_ASSERT_NOW(a_start_ctrl, i_clk, i_rst_n, !empty && o_starts_transfer, o_payload[7:0] == (o_is_data ? CTRL_DATA : CTRL_CMD), "transaction start without control byte")

    `OBD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_payload) && $stable(o_last), "stalled result word changed")

endmodule

bind oled_big_digit_renderer obd_checker #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
) u_obd_checker (.*);
